FILE: rtl/core/owm_pkg.sv
package owm_pkg;

  // Timer and register widths.
  localparam int TIMER_BITS = 10;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 4;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [CNT_W-1:0]      BITS_PER_BYTE = CNT_W'(BYTE_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd600;
  localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd80;
  localparam logic [CFG_W-1:0] RST_RESET_TAIL    = 10'd500;
  localparam logic [CFG_W-1:0] RST_SHORT_PULSE   = 10'd1;
  localparam logic [CFG_W-1:0] RST_SLOT          = 10'd80;
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_REL   = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } phase_e;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_wait_ticks;
    logic [CFG_W-1:0] reset_tail_ticks;
    logic [CFG_W-1:0] short_pulse_ticks;
    logic [CFG_W-1:0] slot_ticks;
    logic [CFG_W-1:0] read_sample_ticks;
  } cfg_t;

  typedef struct packed {
    logic              drive_low;
    logic              busy_res;
    logic              done_res;
    logic              presence;
    logic [BYTE_W-1:0] read_data;
    logic              cmd_ignored;
  } result_t;

  // Phase length in ticks: a zero register counts as one, and a value beyond
  // the timer range saturates.
  function automatic logic [TIMER_BITS-1:0] dur(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] w;
    w = (v == '0) ? CFG_W'(1) : v;
    if (w > CFG_W'(TIMER_MAX)) begin
      return TIMER_MAX;
    end
    return TIMER_BITS'(w);
  endfunction

endpackage

FILE: rtl/core/owm_if.sv
// Tick channel into the master.
interface owm_in_if;
  import owm_pkg::*;
  logic              valid;
  logic              ready;
  op_e               op;
  logic [BYTE_W-1:0] data_byte;
  logic              line_in;
  modport source (output valid, op, data_byte, line_in, input ready);
  modport sink (input valid, op, data_byte, line_in, output ready);
endinterface

// Result channel out of the master.
interface owm_out_if;
  import owm_pkg::*;
  logic              valid;
  logic              ready;
  logic              drive_low;
  logic              busy_res;
  logic              done_res;
  logic              presence;
  logic [BYTE_W-1:0] read_data;
  logic              cmd_ignored;
  modport source (output valid, drive_low, busy_res, done_res, presence, read_data,
                  cmd_ignored, input ready);
  modport sink (input valid, drive_low, busy_res, done_res, presence, read_data,
                cmd_ignored, output ready);
endinterface

// Register write channel.
interface owm_cfg_if;
  import owm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/owm_cfg.sv
module owm_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  owm_cfg_if.sink       cfg_i,
  output owm_pkg::cfg_t regs_o
);
  import owm_pkg::*;

  cfg_t regs_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.reset_low_ticks     <= RST_RESET_LOW;
      regs_q.presence_wait_ticks <= RST_PRESENCE_WAIT;
      regs_q.reset_tail_ticks    <= RST_RESET_TAIL;
      regs_q.short_pulse_ticks   <= RST_SHORT_PULSE;
      regs_q.slot_ticks          <= RST_SLOT;
      regs_q.read_sample_ticks   <= RST_READ_SAMPLE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_RESET_LOW:     regs_q.reset_low_ticks     <= cfg_i.data;
        REG_PRESENCE_WAIT: regs_q.presence_wait_ticks <= cfg_i.data;
        REG_RESET_TAIL:    regs_q.reset_tail_ticks    <= cfg_i.data;
        REG_SHORT_PULSE:   regs_q.short_pulse_ticks   <= cfg_i.data;
        REG_SLOT:          regs_q.slot_ticks          <= cfg_i.data;
        REG_READ_SAMPLE:   regs_q.read_sample_ticks   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign regs_o = regs_q;

endmodule

FILE: rtl/core/owm_engine.sv
module owm_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  owm_pkg::op_e                  op_i,
  input  logic [owm_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic                          line_in_i,
  input  owm_pkg::cfg_t                 cfg_i,
  output owm_pkg::result_t              res_o
);
  import owm_pkg::*;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d, timer_dec;
  logic [BYTE_W-1:0]     shift_q, shift_d, shift_n;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_n;
  op_e                   kind_q, kind_d;
  logic                  presence_q, presence_d;
  logic [BYTE_W-1:0]     last_read_q, last_read_d;
  logic                  done, ignored, finish;

  // Next state for one tick.
  always_comb begin
    phase_d     = phase_q;
    timer_d     = timer_q;
    shift_d     = shift_q;
    cnt_d       = cnt_q;
    kind_d      = kind_q;
    presence_d  = presence_q;
    last_read_d = last_read_q;
    done        = 1'b0;
    ignored     = 1'b0;
    finish      = 1'b0;
    timer_dec   = (timer_q != '0) ? timer_q - TIMER_BITS'(1) : timer_q;
    shift_n     = shift_q >> 1;
    cnt_n       = cnt_q + CNT_W'(1);
    if (fire_i) begin
      if (phase_q == PH_IDLE) begin
        if (op_i != OP_TICK) begin
          kind_d = op_i;
          cnt_d  = '0;
        end
        unique case (op_i)
          OP_TICK: begin
          end
          OP_RESET: begin
            phase_d = PH_RST_LOW;
            timer_d = dur(cfg_i.reset_low_ticks);
          end
          OP_WRITE: begin
            shift_d = data_byte_i;
            phase_d = PH_WR_LOW;
            timer_d = dur(data_byte_i[0] ? cfg_i.short_pulse_ticks : cfg_i.slot_ticks);
          end
          OP_READ: begin
            shift_d = '0;
            phase_d = PH_RD_LOW;
            timer_d = dur(cfg_i.short_pulse_ticks);
          end
        endcase
      end else begin
        ignored = (op_i != OP_TICK);
        timer_d = timer_dec;
        if (timer_dec == '0) begin
          case (phase_q)
            PH_RST_LOW: begin
              phase_d = PH_RST_WAIT;
              timer_d = dur(cfg_i.presence_wait_ticks);
            end
            PH_RST_WAIT: begin
              presence_d = !line_in_i;
              phase_d    = PH_RST_TAIL;
              timer_d    = dur(cfg_i.reset_tail_ticks);
            end
            PH_WR_LOW: begin
              phase_d = PH_WR_REL;
              timer_d = dur(shift_q[0] ? cfg_i.slot_ticks : cfg_i.short_pulse_ticks);
            end
            PH_WR_REL: begin
              shift_d = shift_n;
              cnt_d   = cnt_n;
              if (cnt_n >= BITS_PER_BYTE) begin
                finish = 1'b1;
              end else begin
                phase_d = PH_WR_LOW;
                timer_d = dur(shift_n[0] ? cfg_i.short_pulse_ticks : cfg_i.slot_ticks);
              end
            end
            PH_RD_LOW: begin
              phase_d = PH_RD_WAIT;
              timer_d = dur(cfg_i.read_sample_ticks);
            end
            PH_RD_WAIT: begin
              shift_d = {line_in_i, shift_q[BYTE_W-1:1]};
              phase_d = PH_RD_TAIL;
              timer_d = dur(cfg_i.slot_ticks);
            end
            PH_RD_TAIL: begin
              cnt_d = cnt_n;
              if (cnt_n >= BITS_PER_BYTE) begin
                last_read_d = shift_q;
                finish      = 1'b1;
              end else begin
                phase_d = PH_RD_LOW;
                timer_d = dur(cfg_i.short_pulse_ticks);
              end
            end
            default: finish = 1'b1;
          endcase
        end
        if (finish) begin
          phase_d = PH_IDLE;
          timer_d = '0;
          done    = 1'b1;
        end
      end
    end
  end

  // Result of the tick, taken from the state after it.
  always_comb begin
    res_o.drive_low   = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) ||
                        (phase_d == PH_RD_LOW);
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.done_res    = done;
    res_o.presence    = presence_d;
    res_o.read_data   = last_read_d;
    res_o.cmd_ignored = ignored;
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      timer_q     <= '0;
      shift_q     <= '0;
      cnt_q       <= '0;
      kind_q      <= OP_TICK;
      presence_q  <= 1'b0;
      last_read_q <= '0;
    end else begin
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      shift_q     <= shift_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
      presence_q  <= presence_d;
      last_read_q <= last_read_d;
    end
  end

`ifndef SYNTHESIS
  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> timer_q == '0) else $error("timer running while idle");
  a_busy_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> timer_q != '0) else $error("timer expired in a phase");
  a_busy_has_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> kind_q != OP_TICK) else $error("phase without command");
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= BITS_PER_BYTE) else $error("bit count past one byte");
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && done |=> phase_q == PH_IDLE) else $error("done without return to idle");
`endif

endmodule

FILE: rtl/core/one_wire_bus_master_top.sv
// 1-Wire bus master, one input transaction per bus tick.
// in_i carries op (tick only, reset with presence detect, write byte,
// read byte), data_byte for writes and line_in, the sampled bus level.
// out_o returns one transaction per input tick: drive_low for the bus
// pad, busy and done flags, the presence result of the last reset, the
// byte of the last finished read and a flag for commands dropped while busy.
// cfg_i writes the six timing registers (index 0..5) and is always ready;
// write only while no tick is in flight.
// An accepted tick is held in the input register, and its result is
// registered in the result register before out_o offers it.
// Throughput: one tick per cycle while out_o does not stall; the whole tick
// update is one pass of logic between the input register and the result register.
// Reset clears the sequencer to idle, presence and read byte to zero and the
// timing registers to their defaults. When out_o stalls, the result is held,
// one further tick waits in the input register, and in_i.ready falls.
module one_wire_bus_master_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  owm_in_if.sink   in_i,
  owm_out_if.source out_o,
  owm_cfg_if.sink  cfg_i
);
  import owm_pkg::*;

  cfg_t              regs;
  result_t           res, res_q;
  logic              s1_valid_q, out_valid_q, fire;
  op_e               s1_op_q;
  logic [BYTE_W-1:0] s1_data_q;
  logic              s1_line_q;

  owm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // A tick is processed when the result register is free or being emptied.
  assign fire       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || fire;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q   <= in_i.op;
      s1_data_q <= in_i.data_byte;
      s1_line_q <= in_i.line_in;
    end
  end

  owm_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (s1_op_q),
    .data_byte_i (s1_data_q),
    .line_in_i   (s1_line_q),
    .cfg_i       (regs),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_low   = res_q.drive_low;
  assign out_o.busy_res    = res_q.busy_res;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.presence    = res_q.presence;
  assign out_o.read_data   = res_q.read_data;
  assign out_o.cmd_ignored = res_q.cmd_ignored;

endmodule
